### rtl/hcce_pkg.sv
package hcce_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HASH,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic load_chain;
    logic round_en;
    logic finish;
    logic clear_cnt;
    logic close_eq;
    logic adv_bits;
    logic set_active;
    logic clr_active;
    logic chunk_clr;
    logic chunk_inc;
  } cmd_t;

  typedef struct packed {
    logic round_last;
    logic active;
    logic eq_full;
    logic eq_done;
    logic nbits_zero;
    logic chunk_last;
  } stat_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

  // little-endian byte words to sha message words, byte 0 first
  function automatic logic [255:0] le_to_be(input logic [255:0] v);
    logic [255:0] o;
    o = '0;
    for (int i = 0; i < 32; i++) o[255 - 8*i -: 8] = v[8*i +: 8];
    return o;
  endfunction

endpackage

### rtl/hcce_ctrl.sv
module hcce_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_operation,
  output logic          out_valid,
  input  logic          out_stall,
  input  hcce_pkg::stat_t stat,
  output hcce_pkg::cmd_t  cmd
);
  import hcce_pkg::*;

  state_t state_r, state_nxt;
  logic   op_r, op_nxt;
  logic   acc;
  logic   out_fire;

  assign acc      = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_START;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          op_nxt = in_operation;
          if (in_operation == OP_START) state_nxt = ST_HASH;
          else if (stat.active) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.eq_done) state_nxt = ST_IDLE;
        else state_nxt = ST_HASH;
      end
      ST_HASH: if (stat.round_last) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = (op_r == OP_START) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (out_fire && stat.chunk_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_operation == OP_START) cmd.load_seed = 1'b1;
        if (acc && in_operation == OP_NEXT && stat.active) cmd.close_eq = stat.eq_full;
      end
      ST_CHECK: begin
        if (stat.eq_done) cmd.clr_active = 1'b1;
        else cmd.load_chain = 1'b1;
      end
      ST_HASH: cmd.round_en = 1'b1;
      ST_FINISH: begin
        cmd.finish    = 1'b1;
        cmd.chunk_clr = 1'b1;
        if (op_r == OP_START) begin
          cmd.clear_cnt  = 1'b1;
          cmd.set_active = !stat.nbits_zero;
          cmd.clr_active = stat.nbits_zero;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          cmd.chunk_inc = 1'b1;
          if (stat.chunk_last) cmd.adv_bits = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

### rtl/hcce_dp.sv
module hcce_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  hcce_pkg::cmd_t  cmd,
  output hcce_pkg::stat_t stat,
  input  logic [7:0]    n_bits,
  input  logic [63:0]   seed0,
  input  logic [63:0]   seed1,
  input  logic [63:0]   seed2,
  input  logic [63:0]   seed3,
  output logic [63:0]   coeff_bits,
  output logic [6:0]    valid_count,
  output logic [7:0]    equation_index,
  output logic [15:0]   term_offset,
  output logic          end_of_equation,
  output logic          end_of_matrix,
  output logic          last
);
  import hcce_pkg::*;

  logic [255:0] chain_r, chain_nxt;
  logic [511:0] w_r, w_nxt;
  logic [255:0] st_r, st_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [15:0]  bits_r, bits_nxt;
  logic [7:0]   eq_r, eq_nxt;
  logic         act_r, act_nxt;
  logic [1:0]   chk_r, chk_nxt;

  logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, s0, s1, wnew;
  logic [31:0]  w0, w1, w9, w14;
  logic [255:0] sum;
  logic [8:0]   nu;
  logic [16:0]  nu_prod;
  logic [15:0]  terms, remaining;
  logic [8:0]   take;
  logic [1:0]   nchunks_m1;
  logic [8:0]   valid_full;
  logic         closes;

  assign {a, b, c, d, e, f, g, h} = st_r;
  assign w0  = w_r[511:480];
  assign w1  = w_r[479:448];
  assign w9  = w_r[223:192];
  assign w14 = w_r[63:32];

  always_comb begin
    s0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    wnew = w0 + s0 + w9 + s1;
    t1   = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[rnd_r] + w0;
    t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    for (int i = 0; i < 8; i++) sum[32*i +: 32] = st_r[32*i +: 32] + INIT_H[32*i +: 32];
  end

  // terms per equation
  always_comb begin
    nu         = {1'b0, n_bits} + 9'd8;
    nu_prod    = 17'(({8'd0, nu} + 17'd1) * {8'd0, nu});
    terms      = 16'(nu_prod >> 1) + 16'd1;
    remaining  = terms - bits_r;
    take       = (remaining < 16'd256) ? remaining[8:0] : 9'd256;
    nchunks_m1 = 2'((take - 9'd1) >> 6);
    valid_full = take - {1'b0, chk_r, 6'd0};
    closes     = (remaining <= 16'd256);
  end

  always_comb begin
    chain_nxt = chain_r;
    w_nxt     = w_r;
    st_nxt    = st_r;
    rnd_nxt   = rnd_r;
    bits_nxt  = bits_r;
    eq_nxt    = eq_r;
    act_nxt   = act_r;
    chk_nxt   = chk_r;
    if (cmd.load_seed || cmd.load_chain) begin
      w_nxt   = {le_to_be(cmd.load_seed ? {seed3, seed2, seed1, seed0} : chain_r),
                 32'h80000000, 192'd0, 32'd256};
      st_nxt  = INIT_H;
      rnd_nxt = '0;
    end
    if (cmd.round_en) begin
      w_nxt   = {w_r[479:0], wnew};
      st_nxt  = {t1 + t2, a, b, c, d + t1, e, f, g};
      rnd_nxt = rnd_r + 6'd1;
    end
    if (cmd.finish) chain_nxt = le_to_be(sum);
    if (cmd.clear_cnt) begin
      bits_nxt = '0;
      eq_nxt   = '0;
    end
    if (cmd.close_eq) begin
      eq_nxt   = eq_r + 8'd1;
      bits_nxt = '0;
    end
    if (cmd.adv_bits) begin
      if (closes) begin
        eq_nxt   = eq_r + 8'd1;
        bits_nxt = '0;
        if (eq_r + 8'd1 >= n_bits) act_nxt = 1'b0;
      end else begin
        bits_nxt = bits_r + 16'd256;
      end
    end
    if (cmd.set_active) act_nxt = 1'b1;
    if (cmd.clr_active) act_nxt = 1'b0;
    if (cmd.chunk_clr) chk_nxt = '0;
    if (cmd.chunk_inc) chk_nxt = chk_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
      bits_r  <= '0;
      eq_r    <= '0;
      act_r   <= 1'b0;
      rnd_r   <= '0;
      chk_r   <= '0;
    end else begin
      chain_r <= chain_nxt;
      bits_r  <= bits_nxt;
      eq_r    <= eq_nxt;
      act_r   <= act_nxt;
      rnd_r   <= rnd_nxt;
      chk_r   <= chk_nxt;
    end
    w_r  <= w_nxt;
    st_r <= st_nxt;
  end

  always_comb begin
    logic [63:0] word;
    word = chain_r[64*chk_r +: 64];
    if (valid_full < 9'd64) begin
      valid_count = valid_full[6:0];
      coeff_bits  = word & ((64'd1 << valid_full[5:0]) - 64'd1);
    end else begin
      valid_count = 7'd64;
      coeff_bits  = word;
    end
    last            = (chk_r == nchunks_m1);
    end_of_equation = last && closes;
    end_of_matrix   = end_of_equation && ({1'b0, eq_r} + 9'd1 == {1'b0, n_bits});
    equation_index  = eq_r;
    term_offset     = bits_r + {8'd0, chk_r, 6'd0};
  end

  assign stat.round_last = (rnd_r == 6'd63);
  assign stat.active     = act_r;
  assign stat.eq_full    = (bits_r >= terms);
  assign stat.eq_done    = (eq_r >= n_bits);
  assign stat.nbits_zero = (n_bits == 8'd0);
  assign stat.chunk_last = last;
endmodule

### rtl/hash_chain_coefficient_expand.sv
// A start beat runs one SHA-256 compression over the seed; a next beat, while the matrix is
// active and unfinished, runs one over the chain value, one round per cycle in a shared
// round unit, then hands out up to four 64-bit chunk beats. A start beat gives no output.
// One beat is worked at a time.
module hash_chain_coefficient_expand (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [63:0] in_seed_word0,
  input  logic [63:0] in_seed_word1,
  input  logic [63:0] in_seed_word2,
  input  logic [63:0] in_seed_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_coeff_bits,
  output logic [6:0]  out_valid_count,
  output logic [7:0]  out_equation_index,
  output logic [15:0] out_term_offset,
  output logic        out_end_of_equation,
  output logic        out_end_of_matrix,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hcce_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [7:0] n_bits_r;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, n_bits_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) n_bits_r <= 8'd41;
    else if (psel && penable && pwrite && paddr == 2'd0) n_bits_r <= pwdata[7:0];
  end

  hcce_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation,
    .out_valid, .out_stall, .stat, .cmd
  );

  hcce_dp u_dp (
    .clk, .rst_n, .cmd, .stat, .n_bits(n_bits_r),
    .seed0(in_seed_word0), .seed1(in_seed_word1),
    .seed2(in_seed_word2), .seed3(in_seed_word3),
    .coeff_bits(out_coeff_bits), .valid_count(out_valid_count),
    .equation_index(out_equation_index), .term_offset(out_term_offset),
    .end_of_equation(out_end_of_equation), .end_of_matrix(out_end_of_matrix),
    .last(out_last)
  );

  a_last_eoe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_equation |-> out_last) else $error("eoe without last");
  a_eom_eoe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_matrix |-> out_end_of_equation) else $error("eom without eoe");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during output");
endmodule
